>>> rtl/core/wad_lz_block_decompressor_unit_macros.svh
// ----------------------------------------------------------------------------
// WAD LZ block decompressor - assertion macros
// Shared concurrent assertion forms, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef WAD_LZ_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH
`define WAD_LZ_BLOCK_DECOMPRESSOR_UNIT_MACROS_SVH

// same-cycle implication
`define WLZ_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WLZ_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wlz_pkg.sv
// ----------------------------------------------------------------------------
// WAD LZ decompressor package
// Shared constants and the command format between front and back end.
// ----------------------------------------------------------------------------
package wlz_pkg;

	localparam int unsigned WINDOW_BYTES_DEF = 65536;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned LEN_W = 9;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 104;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_LIT  = 2'd1;
	localparam logic [1:0] KIND_COPY = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        data;
		logic [DIST_W-1:0] offs;
		logic [LEN_W-1:0]  len;
		logic              zero;
		logic              last;
		logic              bad;
	} cmd_t;

endpackage

>>> rtl/core/wlz_front.sv
// ----------------------------------------------------------------------------
// WAD LZ front end
// Parses header and tokens one byte at a time and issues output commands.
// ----------------------------------------------------------------------------
module wlz_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	input  logic                      cfg_we,
	input  logic [wlz_pkg::CFG_W-1:0] cfg_val,
	output logic                      push,
	output wlz_pkg::cmd_t             cmd
);
	import wlz_pkg::*;

	localparam logic [3:0] PH_HDR    = 4'd0;
	localparam logic [3:0] PH_TOKEN  = 4'd1;
	localparam logic [3:0] PH_LITLEN = 4'd2;
	localparam logic [3:0] PH_LIT    = 4'd3;
	localparam logic [3:0] PH_A_EXT  = 4'd4;
	localparam logic [3:0] PH_A_B0   = 4'd5;
	localparam logic [3:0] PH_A_B1   = 4'd6;
	localparam logic [3:0] PH_B_EXT  = 4'd7;
	localparam logic [3:0] PH_B_B1   = 4'd8;
	localparam logic [3:0] PH_B_B2   = 4'd9;
	localparam logic [3:0] PH_C_B1   = 4'd10;
	localparam logic [3:0] PH_SMALL  = 4'd11;
	localparam logic [3:0] PH_PAD    = 4'd12;
	localparam logic [3:0] PH_ALIGN  = 4'd13;

	typedef struct packed {
		logic [3:0]       ph;
		logic [LEN_W-1:0] ml;
		logic [LEN_W-1:0] rem;
	} tok_t;

	logic [3:0]       ph_q, ph_n;
	logic [31:0]      idx_q, idx_n;
	logic [31:0]      size_q, size_n;
	logic [31:0]      pos_q, pos_n;
	logic [7:0]       flag_q, flag_n;
	logic [7:0]       fo_q, fo_n;
	logic [LEN_W-1:0] ml_q, ml_n;
	logic [LEN_W-1:0] rem_q, rem_n;
	logic [LEN_W-1:0] rem_dec;
	logic [DIST_W-1:0] dist_a;
	logic             bad_early;
	logic             fresh;
	tok_t             tok;

	function automatic tok_t start_tok(logic [7:0] b, logic [LEN_W-1:0] ml,
		logic [LEN_W-1:0] rem);
		tok_t t;
		t.ml = ml;
		t.rem = rem;
		t.ph = PH_TOKEN;
		if (b < 8'h10) begin
			if (b != 8'd0) begin
				t.rem = LEN_W'(b) + LEN_W'(3);
				t.ph = PH_LIT;
			end else begin
				t.ph = PH_LITLEN;
			end
		end else if (b < 8'h20) begin
			t.ml = LEN_W'(b[2:0]);
			t.ph = (b[2:0] == 3'd0) ? PH_A_EXT : PH_A_B0;
		end else if (b < 8'h40) begin
			if (b[4:0] == 5'd0) begin
				t.ml = '0;
				t.ph = PH_B_EXT;
			end else begin
				t.ml = LEN_W'(b[4:0]) + LEN_W'(2);
				t.ph = PH_B_B1;
			end
		end else begin
			t.ph = PH_C_B1;
		end
		return t;
	endfunction

	function automatic tok_t finish(logic [7:0] op, logic [LEN_W-1:0] ml,
		logic [LEN_W-1:0] rem);
		tok_t t;
		t.ml = ml;
		t.rem = rem;
		t.ph = PH_TOKEN;
		if (op[1:0] != 2'd0) begin
			t.rem = LEN_W'(op[1:0]);
			t.ph = PH_SMALL;
		end
		return t;
	endfunction

	always_comb begin
		ph_n = ph_q;
		size_n = size_q;
		pos_n = pos_q;
		flag_n = flag_q;
		fo_n = fo_q;
		ml_n = ml_q;
		rem_n = rem_q;
		bad_early = 1'b0;
		fresh = 1'b0;
		tok = '0;
		rem_dec = '0;
		dist_a = '0;
		cmd = '0;
		cmd.kind = KIND_NONE;
		unique case (ph_q)
			PH_HDR: begin
				if (idx_q < 32'd3) begin
					if ((idx_q[1:0] == 2'd0 && data_byte != 8'h57) ||
					    (idx_q[1:0] == 2'd1 && data_byte != 8'h41) ||
					    (idx_q[1:0] == 2'd2 && data_byte != 8'h44))
						bad_early = 1'b1;
				end else if (idx_q < 32'd7) begin
					size_n = size_q | (32'(data_byte) << {idx_q[1:0] - 2'd3, 3'b000});
				end
				if (idx_q >= 32'd15) ph_n = PH_TOKEN;
			end
			PH_TOKEN: begin
				tok = start_tok(data_byte, ml_q, rem_q);
				flag_n = data_byte;
				{ph_n, ml_n, rem_n} = tok;
			end
			PH_PAD: begin
				if (data_byte != 8'hEE) begin
					tok = start_tok(data_byte, ml_q, rem_q);
					flag_n = data_byte;
					{ph_n, ml_n, rem_n} = tok;
				end
			end
			PH_ALIGN: begin
				if (idx_q[11:0] == 12'h010) begin
					tok = start_tok(data_byte, ml_q, rem_q);
					flag_n = data_byte;
					{ph_n, ml_n, rem_n} = tok;
				end
			end
			PH_LITLEN: begin
				rem_n = LEN_W'(data_byte) + LEN_W'(18);
				ph_n = PH_LIT;
			end
			PH_LIT, PH_SMALL: begin
				cmd.kind = KIND_LIT;
				cmd.data = data_byte;
				pos_n = pos_q + 32'd1;
				rem_dec = (rem_q != '0) ? rem_q - LEN_W'(1) : rem_q;
				rem_n = rem_dec;
				if (rem_dec == '0) ph_n = PH_TOKEN;
			end
			PH_A_EXT: begin
				ml_n = LEN_W'(data_byte) + LEN_W'(7);
				ph_n = PH_A_B0;
			end
			PH_A_B0: begin
				fo_n = data_byte;
				ph_n = PH_A_B1;
			end
			PH_A_B1: begin
				dist_a = {1'b0, flag_q[3], 14'd0} + {2'b00, data_byte, 6'd0} +
					DIST_W'(fo_q[7:2]);
				if (flag_q == 8'h12 && fo_q == 8'd0 && data_byte == 8'd0) begin
					ph_n = PH_PAD;
				end else if (dist_a != '0) begin
					cmd.kind = KIND_COPY;
					cmd.offs = dist_a + DIST_W'(16'h4000);
					cmd.len = ml_q + LEN_W'(2);
					tok = finish(fo_q, ml_q, rem_q);
					{ph_n, ml_n, rem_n} = tok;
				end else if (ml_q != LEN_W'(1)) begin
					ph_n = PH_ALIGN;
				end else begin
					tok = finish(fo_q, ml_q, rem_q);
					{ph_n, ml_n, rem_n} = tok;
				end
			end
			PH_B_EXT: begin
				ml_n = LEN_W'(data_byte) + LEN_W'(33);
				ph_n = PH_B_B1;
			end
			PH_B_B1: begin
				fo_n = data_byte;
				ph_n = PH_B_B2;
			end
			PH_B_B2: begin
				cmd.kind = KIND_COPY;
				cmd.offs = {2'b00, data_byte, 6'd0} + DIST_W'(fo_q[7:2]) + DIST_W'(1);
				cmd.len = ml_q;
				tok = finish(fo_q, ml_q, rem_q);
				{ph_n, ml_n, rem_n} = tok;
			end
			PH_C_B1: begin
				cmd.kind = KIND_COPY;
				cmd.offs = {5'd0, data_byte, 3'd0} + DIST_W'(flag_q[4:2]) + DIST_W'(1);
				cmd.len = LEN_W'(flag_q[7:5]) + LEN_W'(1);
				tok = finish(flag_q, ml_q, rem_q);
				{ph_n, ml_n, rem_n} = tok;
			end
			default: ph_n = PH_TOKEN;
		endcase

		if (cmd.kind == KIND_COPY) begin
			cmd.zero = {16'd0, cmd.offs} > pos_q;
			pos_n = pos_q + 32'(cmd.len);
		end

		idx_n = idx_q + 32'd1;
		if (bad_early || (final_byte && idx_n <= 32'd3)) begin
			cmd.kind = KIND_NONE;
			cmd.last = 1'b1;
			cmd.bad = 1'b1;
			fresh = 1'b1;
		end else if (final_byte || (idx_n >= 32'd16 &&
		             {1'b0, idx_n} == {1'b0, size_q} + 33'd16)) begin
			cmd.last = 1'b1;
			fresh = 1'b1;
		end
		push = take && (cmd.kind != KIND_NONE || cmd.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR;
			idx_q <= '0;
			size_q <= '0;
			pos_q <= '0;
			flag_q <= '0;
			fo_q <= '0;
			ml_q <= '0;
			rem_q <= '0;
		end else if (cfg_we) begin
			pos_q <= 32'(cfg_val);
		end else if (take) begin
			pos_q <= pos_n;
			if (fresh) begin
				ph_q <= PH_HDR;
				idx_q <= '0;
				size_q <= '0;
				flag_q <= '0;
				fo_q <= '0;
				ml_q <= '0;
				rem_q <= '0;
			end else begin
				ph_q <= ph_n;
				idx_q <= idx_n;
				size_q <= size_n;
				flag_q <= flag_n;
				fo_q <= fo_n;
				ml_q <= ml_n;
				rem_q <= rem_n;
			end
		end
	end

endmodule

>>> rtl/core/wlz_cmd_fifo.sv
// ----------------------------------------------------------------------------
// WAD LZ command queue
// Short FIFO that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
module wlz_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wlz_pkg::cmd_t push_cmd,
	input  logic          pop,
	output wlz_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import wlz_pkg::*;

	localparam int unsigned PW = $clog2(FIFO_DEPTH);

	cmd_t        mem_q [FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (PW+1)'(FIFO_DEPTH));
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + PW'(1);
			if (pop && !empty) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule

>>> rtl/core/wlz_back.sv
// ----------------------------------------------------------------------------
// WAD LZ back end
// Executes commands against the history window and packs output words.
// ----------------------------------------------------------------------------
module wlz_back #(
	parameter int unsigned WINDOW_BYTES = wlz_pkg::WINDOW_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [wlz_pkg::CFG_W-1:0] cfg_val,
	input  wlz_pkg::cmd_t             head,
	input  logic                      empty,
	output logic                      pop,
	output logic                      clr_busy,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [63:0]               out_word,
	output logic [3:0]                out_cnt,
	output logic                      out_done,
	output logic                      out_bad,
	output logic [31:0]               out_total
);
	import wlz_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_BYTES);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	logic [7:0]       hist [WINDOW_BYTES];
	logic [7:0]       rd_q;
	logic [1:0]       st_q;
	logic [AW-1:0]    clr_q, wr_q, src_q;
	logic [LEN_W-1:0] rem_q;
	logic             zero_q, end_q;
	logic [63:0]      acc_q, acc_v;
	logic [3:0]       accn_q;
	logic [31:0]      wcnt_q;
	logic [7:0]       byte_v;
	logic             last_v, emit_v, slot_free, adv;
	logic             we, re, ld;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic [63:0]      ld_word;
	logic [3:0]       ld_cnt;
	logic             ld_done, ld_bad;
	logic [31:0]      ld_tot;

	assign clr_busy = (st_q == ST_CLR);
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		byte_v = zero_q ? 8'd0 : rd_q;
		last_v = (rem_q == LEN_W'(1));
		emit_v = last_v || (accn_q == 4'd7);
		acc_v = acc_q | (64'(byte_v) << {accn_q[2:0], 3'b000});
		pop = 1'b0;
		adv = 1'b0;
		we = 1'b0;
		re = 1'b0;
		ld = 1'b0;
		waddr = wr_q;
		wdata = byte_v;
		ld_word = acc_v;
		ld_cnt = accn_q + 4'd1;
		ld_done = last_v && end_q;
		ld_bad = 1'b0;
		ld_tot = wcnt_q + 32'd1;
		unique case (st_q)
			ST_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = 8'd0;
			end
			ST_IDLE: begin
				if (!empty) begin
					case (head.kind)
						KIND_LIT: begin
							if (slot_free) begin
								pop = 1'b1;
								we = 1'b1;
								wdata = head.data;
								ld = 1'b1;
								ld_word = 64'(head.data);
								ld_cnt = 4'd1;
								ld_done = head.last;
							end
						end
						KIND_COPY: pop = 1'b1;
						default: begin
							if (slot_free) begin
								pop = 1'b1;
								ld = 1'b1;
								ld_word = '0;
								ld_cnt = 4'd0;
								ld_done = 1'b1;
								ld_bad = head.bad;
								ld_tot = head.bad ? 32'd0 : wcnt_q;
							end
						end
					endcase
				end
			end
			ST_RD: re = 1'b1;
			ST_WR: begin
				if (!emit_v || slot_free) begin
					adv = 1'b1;
					we = 1'b1;
					ld = emit_v;
				end
			end
			default: ;
		endcase
	end

	// history window, registered read
	always_ff @(posedge clk) begin
		if (we) hist[waddr] <= wdata;
		if (re) rd_q <= hist[src_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			wr_q <= '0;
			wcnt_q <= '0;
			accn_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (ld) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cfg_we) wr_q <= AW'(cfg_val);
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == KIND_COPY) begin
							st_q <= ST_RD;
							accn_q <= '0;
						end else if (head.kind == KIND_LIT) begin
							wr_q <= wr_q + AW'(1);
							wcnt_q <= head.last ? 32'd0 : wcnt_q + 32'd1;
						end else begin
							wcnt_q <= '0;
						end
					end
				end
				ST_RD: st_q <= ST_WR;
				ST_WR: begin
					if (adv) begin
						wr_q <= wr_q + AW'(1);
						wcnt_q <= (last_v && end_q) ? 32'd0 : wcnt_q + 32'd1;
						accn_q <= emit_v ? 4'd0 : accn_q + 4'd1;
						st_q <= last_v ? ST_IDLE : ST_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// copy payload
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && pop) begin
			src_q <= wr_q - AW'(head.offs);
			rem_q <= head.len;
			zero_q <= head.zero;
			end_q <= head.last;
			acc_q <= '0;
		end else if (st_q == ST_RD) begin
			src_q <= src_q + AW'(1);
		end else if (adv) begin
			rem_q <= rem_q - LEN_W'(1);
			acc_q <= emit_v ? 64'd0 : acc_v;
		end
		if (ld) begin
			out_word <= ld_word;
			out_cnt <= ld_cnt;
			out_done <= ld_done;
			out_bad <= ld_bad;
			out_total <= ld_tot;
		end
	end

endmodule

>>> rtl/core/wad_lz_block_decompressor_unit.sv
// ----------------------------------------------------------------------------
// WAD LZ block decompressor unit
// A literal byte reaches m_tdata via the command queue and the output register.
// Rate: 1 literal byte/cycle if not stalled; a copy reads then writes each byte.
// Reset: clears control, then a clear of the whole window holds s_tready low.
// ----------------------------------------------------------------------------
`include "wad_lz_block_decompressor_unit_macros.svh"

module wad_lz_block_decompressor_unit #(
	parameter int unsigned WINDOW_BYTES = wlz_pkg::WINDOW_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// compressed input: tdata = data_byte[7:0]; tlast = final_byte
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wlz_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	// decoded output: tdata = word[63:0], byte_count[67:64],
	//   total_written[99:68], zero fill [103:100]; tuser = bad_header;
	//   tlast = stream_done
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wlz_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast,
	// start_offset register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wlz_pkg::CFG_W-1:0]       cfg_data
);
	import wlz_pkg::*;

	logic        take, cfg_we;
	logic        push, pop, empty, full, clr_busy;
	cmd_t        cmd, head;
	logic [63:0] o_word;
	logic [3:0]  o_cnt;
	logic [31:0] o_tot;

	// config always taken; the user writes it only while the block is idle (unchecked)
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid;

	// hold the input while the window is being cleared or the queue is full
	assign s_tready = !full && !clr_busy;
	assign take = s_tvalid && s_tready;

	// front end: header check, token parse, block end detection
	wlz_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (s_tdata[7:0]),
		.final_byte (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_val    (cfg_data),
		.push       (push),
		.cmd        (cmd)
	);

	// command queue between parser and copy engine
	wlz_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// back end: history window, match copy, word packing, output register
	wlz_back #(
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_val   (cfg_data),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.clr_busy  (clr_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (o_word),
		.out_cnt   (o_cnt),
		.out_done  (m_tlast),
		.out_bad   (m_tuser),
		.out_total (o_tot)
	);

	assign m_tdata = {4'd0, o_tot, o_cnt, o_word};

	`WLZ_ASSERT_IMP(a_no_take_clr, clr_busy, !s_tready, "transfer during window clear")
	`WLZ_ASSERT_IMP(a_bad_empty, m_tvalid && m_tuser, m_tlast && (o_cnt == 4'd0), "bad not empty")
	`WLZ_ASSERT_IMP(a_cnt_range, m_tvalid, o_cnt <= 4'd8, "byte count beyond eight")
	`WLZ_ASSERT_NXT(a_no_push_full, full && !pop, !(push && $past(full)) || full, "queue overflow")

endmodule
